@@ rtl/core/dacwg_pkg.sv @@
// Shared types, constants and the sine table builder for the DAC waveform generator.
// No dependencies; every other file in rtl/core imports this package.
package dacwg_pkg;

    // Default widths for the top-level parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int DAC_BITS_DEF        = 10;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int DUTY_BITS      = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SINE_Q16_BITS  = 17;
    localparam int PERCENT_FULL   = 100;

    // Reset values of the configuration registers
    localparam int unsigned PHASE_INC_RESET = 429497;
    localparam int unsigned DUTY_RESET      = 50;

    // Fixed-point constants of the quarter-wave sine
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_PULSE = 2'd0,
        WAVE_SINE  = 2'd1,
        WAVE_TRI   = 2'd2,
        WAVE_RAMP  = 2'd3
    } wave_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WAVE_SELECT     = 3'd0,
        REG_PHASE_INCREMENT = 3'd1,
        REG_AMPLITUDE_CODE  = 3'd2,
        REG_OFFSET_CODE     = 3'd3,
        REG_DUTY_PERCENT    = 3'd4
    } cfg_reg_t;

    // Quarter sine of angle k * (pi/2) / 2^qbits in unsigned Q30, Taylor series to x^11
    // in Horner form, each step truncated, clamped to one. Evaluated at elaboration only.
    function automatic logic [30:0] quarter_sine_q30(input int unsigned k,
                                                     input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(k) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        return s[30:0];
    endfunction

endpackage

@@ rtl/core/dacwg_if.sv @@
// Valid/ready channel interfaces for the DAC waveform generator: tick input, sample output.
// Depends on dacwg_pkg for default widths.
interface dacwg_tick_if import dacwg_pkg::*;;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface dacwg_sample_if import dacwg_pkg::*; #(
    parameter int DAC_BITS = DAC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [DAC_BITS-1:0] dac_code;
    logic                clipped;

    modport source (output valid, output dac_code, output clipped, input ready);
    modport sink   (input valid, input dac_code, input clipped, output ready);
endinterface

@@ rtl/core/dac_waveform_generator_top.sv @@
// Three register stages (phase, swing, output), which a sample passes in that order.
// Throughput: one tick per cycle while a stage is free or the sample sink is ready;
// the phase accumulator add is the only loop-carried path.
// Ticks with the tick bit low are taken without a result and leave the phase untouched.
// Reset (rst_n low, asynchronous): phase clears to zero, pipeline empties, configuration
// returns to square wave, increment 429497, amplitude 0, offset 0, duty 50.
// Depends on dacwg_pkg, dacwg_if and dacwg_swing.
module dac_waveform_generator_top import dacwg_pkg::*; #(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int DAC_BITS        = DAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PHASE_BITS-1:0]     cfg_data,
    dacwg_tick_if.sink                tick_chan,
    dacwg_sample_if.source            sample_chan
);

    // ------------------------------------------------------------------
    // Configuration registers; writes beyond the list are dropped
    // ------------------------------------------------------------------
    wave_t                 wave_reg;
    logic [PHASE_BITS-1:0] phase_inc_reg;
    logic [DAC_BITS-1:0]   amplitude_reg;
    logic [DAC_BITS-1:0]   offset_reg;
    logic [DUTY_BITS-1:0]  duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg      <= WAVE_PULSE;
            phase_inc_reg <= PHASE_BITS'(PHASE_INC_RESET);
            amplitude_reg <= '0;
            offset_reg    <= '0;
            duty_reg      <= DUTY_BITS'(DUTY_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WAVE_SELECT:     wave_reg      <= wave_t'(cfg_data[1:0]);
                REG_PHASE_INCREMENT: phase_inc_reg <= cfg_data;
                REG_AMPLITUDE_CODE:  amplitude_reg <= cfg_data[DAC_BITS-1:0];
                REG_OFFSET_CODE:     offset_reg    <= cfg_data[DAC_BITS-1:0];
                REG_DUTY_PERCENT:    duty_reg      <= cfg_data[DUTY_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage advances when it is empty or the
    // stage after it advances, so bubbles collapse and a full output
    // register does not block a new transfer until every stage is full.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic in_xfer;
    logic sample_xfer;

    assign out_adv     = !out_valid_reg || sample_chan.ready;
    assign s2_adv      = !s2_valid_reg || out_adv;
    assign s1_adv      = !s1_valid_reg || s2_adv;
    assign tick_chan.ready = s1_adv;
    assign in_xfer     = tick_chan.valid && tick_chan.ready;
    // Only a transfer with the tick bit set produces a sample and steps the phase
    assign sample_xfer = in_xfer && tick_chan.tick;

    // ------------------------------------------------------------------
    // Phase accumulator: wraps modulo 2^PHASE_BITS; sample uses the value
    // before the step
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] s1_phase_reg;

    assign phase_acc_next = phase_acc_reg + phase_inc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else if (sample_xfer)
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // Stage 1: hold the phase of the sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= sample_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && sample_xfer)
        begin
            s1_phase_reg <= phase_acc_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: swing above offset for the selected waveform
    // ------------------------------------------------------------------
    logic [DAC_BITS-1:0] swing;
    logic [DAC_BITS-1:0] s2_swing_reg;

    dacwg_swing #(
        .PHASE_BITS      (PHASE_BITS),
        .DAC_BITS        (DAC_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_swing (
        .wave      (wave_reg),
        .amplitude (amplitude_reg),
        .duty      (duty_reg),
        .phase     (s1_phase_reg),
        .swing     (swing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_swing_reg <= swing;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add offset, saturate at full scale and flag the clip
    // ------------------------------------------------------------------
    logic [DAC_BITS:0]   sum;
    logic [DAC_BITS-1:0] code_next;
    logic                clip_next;
    logic [DAC_BITS-1:0] out_code_reg;
    logic                out_clip_reg;

    assign sum       = {1'b0, offset_reg} + {1'b0, s2_swing_reg};
    assign clip_next = sum[DAC_BITS];
    assign code_next = clip_next ? {DAC_BITS{1'b1}} : sum[DAC_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            out_code_reg <= code_next;
            out_clip_reg <= clip_next;
        end
    end

    assign sample_chan.valid    = out_valid_reg;
    assign sample_chan.dac_code = out_code_reg;
    assign sample_chan.clipped  = out_clip_reg;

`ifndef SYNTHESIS
    // Phase moves only on a transfer that carries a tick
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_xfer |=> $stable(phase_acc_reg))
        else $error("phase accumulator moved without a tick transfer");

    // Phase steps by the increment in force at the transfer
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> phase_acc_reg == PHASE_BITS'($past(phase_acc_reg)
                                                     + $past(phase_inc_reg)))
        else $error("phase accumulator did not advance by the increment");

    // A clipped sample is always at full scale
    a_clip_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clip_reg |-> out_code_reg == {DAC_BITS{1'b1}})
        else $error("clipped sample below full scale");

    // Input stalls only when every stage holds a sample and the sink stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_chan.ready |-> s1_valid_reg && s2_valid_reg && out_valid_reg
                             && !sample_chan.ready)
        else $error("input stalled with a free pipeline stage");
`endif

endmodule

@@ rtl/core/dacwg_swing.sv @@
// Swing above offset for one phase sample: square compare, sine table, shared multiplier.
// Depends on dacwg_pkg for the wave codes and the sine table builder.
module dacwg_swing import dacwg_pkg::*; #(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int DAC_BITS        = DAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wave_t                 wave,
    input  logic [DAC_BITS-1:0]   amplitude,
    input  logic [DUTY_BITS-1:0]  duty,
    input  logic [PHASE_BITS-1:0] phase,
    output logic [DAC_BITS-1:0]   swing
);

    localparam int QBITS    = SINE_TABLE_BITS - 2;
    localparam int QN       = 1 << QBITS;
    localparam int MUL_BITS = PHASE_BITS + 1;
    localparam int PROD_BITS = DAC_BITS + MUL_BITS;
    localparam int SQ_BITS  = PHASE_BITS + DUTY_BITS;

    // Quarter-wave table, upper and lower half-period values in Q16
    logic [SINE_Q16_BITS-1:0] sine_hi [QN+1];
    logic [SINE_Q16_BITS-1:0] sine_lo [QN+1];

    for (genvar g = 0; g <= QN; g++)
    begin : g_sine_rom
        localparam logic [30:0] S_Q30 = quarter_sine_q30(g, QBITS);
        assign sine_hi[g] = SINE_Q16_BITS'((Q30_ONE + 64'(S_Q30)) >> 15);
        assign sine_lo[g] = SINE_Q16_BITS'((Q30_ONE - 64'(S_Q30)) >> 15);
    end

    logic [SINE_TABLE_BITS-1:0] sine_idx;
    logic [1:0]                 quad;
    logic [QBITS-1:0]           quad_pos;
    logic [QBITS:0]             rom_idx;
    logic [SINE_Q16_BITS-1:0]   sine_q16;
    logic [PHASE_BITS-1:0]      tri_mag;
    logic [MUL_BITS-1:0]        mul_b;
    logic [PROD_BITS-1:0]       prod;
    logic [SQ_BITS-1:0]         sq_lhs;
    logic [SQ_BITS-1:0]         sq_rhs;
    logic                       sq_high;

    // Mirror odd quadrants, pick the lower table in the second half-period
    assign sine_idx = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad     = sine_idx[SINE_TABLE_BITS-1 -: 2];
    assign quad_pos = sine_idx[QBITS-1:0];
    assign rom_idx  = quad[0] ? ((QBITS+1)'(QN) - {1'b0, quad_pos}) : {1'b0, quad_pos};
    assign sine_q16 = quad[1] ? sine_lo[rom_idx] : sine_hi[rom_idx];

    // Distance from the nearest period end; the two's complement covers the peak too
    assign tri_mag = phase[PHASE_BITS-1] ? (~phase + 1'b1) : phase;

    // Square high while phase * 100 <= duty * 2^P
    assign sq_lhs  = SQ_BITS'(phase) * SQ_BITS'(PERCENT_FULL);
    assign sq_rhs  = {duty, {PHASE_BITS{1'b0}}};
    assign sq_high = (sq_lhs <= sq_rhs);

    // Align every operand so the swing sits at bit PHASE_BITS of the product
    always_comb
    begin
        case (wave)
            WAVE_SINE: mul_b = MUL_BITS'(sine_q16) << (PHASE_BITS - 16);
            WAVE_TRI:  mul_b = {tri_mag, 1'b0};
            WAVE_RAMP: mul_b = {1'b0, phase};
            default:   mul_b = '0;
        endcase
    end

    assign prod = PROD_BITS'(amplitude) * PROD_BITS'(mul_b);

    always_comb
    begin
        case (wave)
            WAVE_PULSE: swing = sq_high ? amplitude : '0;
            default:    swing = prod[PHASE_BITS +: DAC_BITS];
        endcase
    end

endmodule
